FILE: hdl/slt_pkg.sv
// ----------------------------------------------------------------------------
// slt_pkg - shared types and codes for the sorted list table
// Table depth, index and count widths, operation and status codes.
// ----------------------------------------------------------------------------
package slt_pkg;

  localparam int DEPTH        = 16;
  localparam int IDX_W        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W        = $clog2(DEPTH + 1);
  localparam int POS_W        = 4;
  localparam int CMP_W        = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int RESULT_LIMIT = 16;
  localparam bit LIMITED      = DEPTH > RESULT_LIMIT;

  typedef logic signed [31:0] word_t;
  typedef logic [IDX_W-1:0]   idx_t;
  typedef logic [CNT_W-1:0]   cnt_t;

  localparam logic [1:0] OP_INSERT     = 2'd0;
  localparam logic [1:0] OP_REMOVE_AT  = 2'd1;
  localparam logic [1:0] OP_REMOVE_VAL = 2'd2;
  localparam logic [1:0] OP_DUMP       = 2'd3;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_FULL      = 3'd1;
  localparam logic [2:0] ST_EMPTY     = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_BAD_POS   = 3'd4;

endpackage

FILE: hdl/sorted_list_table.sv
// One result register. A full insert, an empty table or a bad position goes
// straight to it; insert shifts larger entries up, remove at position shifts
// those above down, remove by value compacts, dump sends out each entry.
// Throughput: one item at a time; the next item is taken when the sequencer
// returns to idle, set by the single read port of the entry memory.
// Reset clears the sequencer, the count and the result valid; entries are
// not cleared and are only read below the count.
// ----------------------------------------------------------------------------
// sorted_list_table - ordered table of signed values
// Sequencer over an entry memory with one write and one read port and one shared compare unit.
// ----------------------------------------------------------------------------
module sorted_list_table (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  operation,
  input  logic signed [31:0] item_value,
  input  logic [3:0]  position,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic signed [31:0] entry_value,
  output logic [4:0]  entry_count,
  output logic        last
);
  import slt_pkg::*;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_INS_RD  = 4'd1;
  localparam logic [3:0] S_INS_CMP = 4'd2;
  localparam logic [3:0] S_DEL_RD  = 4'd3;
  localparam logic [3:0] S_DEL_WR  = 4'd4;
  localparam logic [3:0] S_RV_RD   = 4'd5;
  localparam logic [3:0] S_RV_CMP  = 4'd6;
  localparam logic [3:0] S_DMP_RD  = 4'd7;
  localparam logic [3:0] S_DMP_OUT = 4'd8;
  localparam logic [3:0] S_RESULT  = 4'd9;

  logic [3:0] state, state_next;
  cnt_t       count, count_next;
  cnt_t       idx, idx_next;
  cnt_t       widx, widx_next;
  word_t      val, val_next;
  logic [2:0] res_status, res_status_next;

  logic       out_valid_next;
  logic [2:0] status_next;
  word_t      entry_value_next;
  logic [4:0] entry_count_next;
  logic       last_next;

  logic  wr_en, rd_en;
  idx_t  wr_addr, rd_addr;
  word_t wr_data, rd_data;
  logic  lt, eq;

  logic  accept, slot_free, dump_last;
  cnt_t  idx_p1, idx_m1;

  slt_ram u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  slt_cmp u_cmp (
    .a  (val),
    .b  (rd_data),
    .lt (lt),
    .eq (eq)
  );

  assign in_stall  = state != S_IDLE;
  assign accept    = in_valid && !in_stall;
  assign slot_free = !out_valid || !out_stall;
  assign idx_p1    = idx + cnt_t'(1);
  assign idx_m1    = idx - cnt_t'(1);
  assign dump_last = (idx_p1 == count) ||
                     (LIMITED && (idx_p1 == cnt_t'(RESULT_LIMIT)));

  always_comb begin
    state_next       = state;
    count_next       = count;
    idx_next         = idx;
    widx_next        = widx;
    val_next         = val;
    res_status_next  = res_status;
    out_valid_next   = out_valid && out_stall;
    status_next      = status;
    entry_value_next = entry_value;
    entry_count_next = entry_count;
    last_next        = last;
    wr_en            = 1'b0;
    wr_addr          = idx[IDX_W-1:0];
    wr_data          = val;
    rd_en            = 1'b0;
    rd_addr          = idx[IDX_W-1:0];

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          val_next        = item_value;
          res_status_next = ST_OK;
          unique case (operation)
            OP_INSERT: begin
              if (count == cnt_t'(DEPTH)) begin
                res_status_next = ST_FULL;
                state_next      = S_RESULT;
              end else begin
                idx_next   = count;
                state_next = S_INS_RD;
              end
            end
            OP_REMOVE_AT: begin
              if (count == '0) begin
                res_status_next = ST_EMPTY;
                state_next      = S_RESULT;
              end else if (CMP_W'(position) >= CMP_W'(count)) begin
                res_status_next = ST_BAD_POS;
                state_next      = S_RESULT;
              end else begin
                idx_next   = cnt_t'(position);
                state_next = S_DEL_RD;
              end
            end
            OP_REMOVE_VAL: begin
              idx_next   = '0;
              widx_next  = '0;
              state_next = S_RV_RD;
            end
            OP_DUMP: begin
              if (count == '0) begin
                res_status_next = ST_EMPTY;
                state_next      = S_RESULT;
              end else begin
                idx_next   = '0;
                state_next = S_DMP_RD;
              end
            end
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_INS_RD: begin
        if (idx == '0) begin
          wr_en      = 1'b1;
          count_next = count + cnt_t'(1);
          state_next = S_RESULT;
        end else begin
          rd_en      = 1'b1;
          rd_addr    = idx_m1[IDX_W-1:0];
          state_next = S_INS_CMP;
        end
      end
      S_INS_CMP: begin
        // shift the larger entry up, or drop the value into the hole
        wr_en = 1'b1;
        if (lt) begin
          wr_data    = rd_data;
          idx_next   = idx_m1;
          state_next = S_INS_RD;
        end else begin
          count_next = count + cnt_t'(1);
          state_next = S_RESULT;
        end
      end
      S_DEL_RD: begin
        if (idx_p1 < count) begin
          rd_en      = 1'b1;
          rd_addr    = idx_p1[IDX_W-1:0];
          state_next = S_DEL_WR;
        end else begin
          count_next = count - cnt_t'(1);
          state_next = S_RESULT;
        end
      end
      S_DEL_WR: begin
        wr_en      = 1'b1;
        wr_data    = rd_data;
        idx_next   = idx_p1;
        state_next = S_DEL_RD;
      end
      S_RV_RD: begin
        if (idx < count) begin
          rd_en      = 1'b1;
          state_next = S_RV_CMP;
        end else begin
          res_status_next = (widx != count) ? ST_OK : ST_NOT_FOUND;
          count_next      = widx;
          state_next      = S_RESULT;
        end
      end
      S_RV_CMP: begin
        // compact: keep every entry that differs from the value
        if (!eq) begin
          wr_en     = 1'b1;
          wr_addr   = widx[IDX_W-1:0];
          wr_data   = rd_data;
          widx_next = widx + cnt_t'(1);
        end
        idx_next   = idx_p1;
        state_next = S_RV_RD;
      end
      S_DMP_RD: begin
        rd_en      = 1'b1;
        state_next = S_DMP_OUT;
      end
      S_DMP_OUT: begin
        if (slot_free) begin
          out_valid_next   = 1'b1;
          status_next      = ST_OK;
          entry_value_next = rd_data;
          entry_count_next = 5'(count);
          last_next        = dump_last;
          idx_next         = idx_p1;
          state_next       = dump_last ? S_IDLE : S_DMP_RD;
        end
      end
      S_RESULT: begin
        if (slot_free) begin
          out_valid_next   = 1'b1;
          status_next      = res_status;
          entry_value_next = '0;
          entry_count_next = 5'(count);
          last_next        = 1'b1;
          state_next       = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    idx         <= idx_next;
    widx        <= widx_next;
    val         <= val_next;
    res_status  <= res_status_next;
    status      <= status_next;
    entry_value <= entry_value_next;
    entry_count <= entry_count_next;
    last        <= last_next;
  end

endmodule

FILE: hdl/slt_ram.sv
// ----------------------------------------------------------------------------
// slt_ram - entry storage
// One write port and one registered read port; read data holds between reads.
// ----------------------------------------------------------------------------
module slt_ram (
  input  logic          clk,
  input  logic          wr_en,
  input  slt_pkg::idx_t wr_addr,
  input  slt_pkg::word_t wr_data,
  input  logic          rd_en,
  input  slt_pkg::idx_t rd_addr,
  output slt_pkg::word_t rd_data
);
  import slt_pkg::*;

  word_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: hdl/slt_cmp.sv
// ----------------------------------------------------------------------------
// slt_cmp - shared compare unit
// Signed less-than and equality of the operand value against a stored entry.
// ----------------------------------------------------------------------------
module slt_cmp (
  input  slt_pkg::word_t a,
  input  slt_pkg::word_t b,
  output logic           lt,
  output logic           eq
);
  import slt_pkg::*;

  assign lt = a < b;
  assign eq = a == b;

endmodule
